FILE: rtl/shad_pkg.sv
// Package for the SHA-256d nonce search block: types, constants, round functions.
// Used by every module under rtl/.
`default_nettype none
package shad_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PREPARE = 2'd1,
    MODE_HASH    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned NumHdr     = 20;
  localparam int unsigned NumTgt     = 8;
  localparam logic [4:0]  TgtBase    = 5'd20;
  localparam logic [4:0]  TgtEnd     = 5'd28;
  localparam logic [31:0] PadWord    = 32'h80000000;
  localparam logic [31:0] Len640Word = 32'h00000280;
  localparam logic [31:0] Len256Word = 32'h00000100;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;
  typedef word_t [15:0] sched_t;

  // Control bits that ride alongside the state through a round chain.
  typedef struct packed {
    logic  vld;
    logic  is_hash;
  } tag_t;

  localparam word_t KRound [NumRounds] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam state_t HInit = {
    32'h5be0cd19,32'h1f83d9ab,32'h9b05688c,32'h510e527f,
    32'ha54ff53a,32'h3c6ef372,32'hbb67ae85,32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap(input word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/shad_round_cell.sv
// One SHA-256 round cell: one round of the working state plus one schedule step.
// Depends on shad_pkg.
`default_nettype none
module shad_round_cell
  import shad_pkg::*;
#(
  parameter int unsigned Round = 0
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    en_i,
  input  tag_t   tag_i,
  input  state_t wst_i,
  input  state_t init_i,
  input  sched_t w_i,
  output tag_t   tag_o,
  output state_t wst_o,
  output state_t init_o,
  output sched_t w_o
);

  logic   vld_q, is_hash_q;
  state_t wst_q, wst_d, init_q;
  sched_t w_q, w_d;
  word_t  t1, t2;

  // Working state is held as {h,g,f,e,d,c,b,a} from index 7 down to 0.
  always_comb begin
    t1 = wst_i[7] + bsig1(wst_i[4]) + ((wst_i[4] & wst_i[5]) ^ (~wst_i[4] & wst_i[6]))
         + KRound[Round] + w_i[0];
    t2 = bsig0(wst_i[0]) + ((wst_i[0] & wst_i[1]) ^ (wst_i[0] & wst_i[2])
         ^ (wst_i[1] & wst_i[2]));
    wst_d = {wst_i[6], wst_i[5], wst_i[4], wst_i[3] + t1,
             wst_i[2], wst_i[1], wst_i[0], t1 + t2};
    // The window slides by one; the new tail word is the next schedule entry.
    w_d = {w_i[0] + sig0(w_i[1]) + w_i[9] + sig1(w_i[14]), w_i[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tag_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      is_hash_q <= tag_i.is_hash;
      wst_q     <= wst_d;
      init_q    <= init_i;
      w_q       <= w_d;
    end
  end

  assign tag_o  = '{vld: vld_q, is_hash: is_hash_q};
  assign wst_o  = wst_q;
  assign init_o = init_q;
  assign w_o    = w_q;

endmodule
`default_nettype wire

FILE: rtl/shad_compress.sv
// A 64-cell SHA-256 compression chain with the final feed-forward add registered.
// Depends on shad_pkg and shad_round_cell.
`default_nettype none
module shad_compress
  import shad_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    en_i,
  input  tag_t   tag_i,
  input  state_t init_i,
  input  sched_t msg_i,
  output tag_t   tag_o,
  output state_t digest_o
);

  tag_t   tag_c [NumRounds+1];
  state_t wst_c [NumRounds+1];
  state_t ini_c [NumRounds+1];
  sched_t w_c   [NumRounds+1];
  logic   vld_q, is_hash_q;
  state_t dig_q;

  assign tag_c[0] = tag_i;
  assign wst_c[0] = init_i;
  assign ini_c[0] = init_i;
  assign w_c[0]   = msg_i;

  for (genvar r = 0; r < NumRounds; r++) begin : g_cell
    shad_round_cell #(.Round(r)) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en_i),
      .tag_i (tag_c[r]), .wst_i(wst_c[r]), .init_i(ini_c[r]), .w_i(w_c[r]),
      .tag_o (tag_c[r+1]), .wst_o(wst_c[r+1]), .init_o(ini_c[r+1]), .w_o(w_c[r+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= tag_c[NumRounds].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      is_hash_q <= tag_c[NumRounds].is_hash;
      for (int i = 0; i < 8; i++) begin
        dig_q[i] <= ini_c[NumRounds][i] + wst_c[NumRounds][i];
      end
    end
  end

  assign tag_o    = '{vld: vld_q, is_hash: is_hash_q};
  assign digest_o = dig_q;

endmodule
`default_nettype wire

FILE: rtl/sha256d_nonce_search.sv
// Top level of the SHA-256d nonce search: stores, two compression chains, result stage.
// Depends on shad_pkg and shad_compress.
//
// Usage. The input channel (in_valid_i/in_ready_o) carries one request per item:
// mode 0 loads a header or target word, mode 1 computes the midstate from header
// words 0..15 and latches target word 7, mode 2 hashes one nonce, mode 3 is dropped.
// Load items take effect at acceptance and give no result. Prepare and hash items
// enter a chain of 64 round cells; hash items then pass a second 64-cell chain for
// the outer SHA-256 and then reach the output register through its digest register.
// A miss gives one result; a hit gives four results, chunk 0 to 3, last on chunk 3.
// Throughput is one hash request per cycle while the receiver keeps up; the output
// stage then holds a hit for its four chunks, which sets the sustained rate for hits.
// The whole pipeline advances as one unit: when the output stage holds a result the
// receiver has not taken (or is still sending hit chunks), every cell holds and
// in_ready_o falls. A hash request also waits while a prepare is in the first chain,
// and a prepare or a target word load waits until every hash in flight has reached
// the output stage. Reset clears all valid flags and counters; the stores, midstate
// and target top are undefined until written.
`default_nettype none
module sha256d_nonce_search
  import shad_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [1:0]   mode_i,
  input  wire  [4:0]   word_index_i,
  input  wire  [31:0]  word_value_i,
  input  wire  [31:0]  nonce_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic         candidate_o,
  output logic         share_o,
  output logic [1:0]   chunk_index_o,
  output logic [63:0]  hash_chunk_o,
  output logic         last_o
);

  word_t  hdr_q [NumHdr];
  word_t  tgt_q [NumTgt];
  state_t mid_q;
  word_t  ttop_q;

  logic   adv, acc, blocked, prep_done;
  mode_e  mode;
  tag_t   tag1_in, tag1_out, tag2_in, tag2_out;
  sched_t msg1, msg2;
  state_t init1, dig1, dig2;

  // Requests in flight: hashes up to the output stage, prepares in the first chain.
  logic [7:0] hcnt_q, hcnt_d;
  logic [6:0] pcnt_q, pcnt_d;

  // Output stage.
  logic       ov_q, ov_d, hit_q, hit_d, share_q, share_d;
  logic [1:0] cnt_q, cnt_d;
  word_t      limb_q [8];
  logic       take_new, share_c, decided;
  word_t      limb_c [8];

  assign mode = mode_e'(mode_i);
  // Pipeline may shift when the output register is free or its final result leaves.
  assign adv  = !ov_q || (out_ready_i && (!hit_q || cnt_q == 2'd3));
  // A hash needs the finished midstate; the target must stay put under in-flight hashes.
  assign blocked = (mode == MODE_HASH && pcnt_q != 7'd0)
                || (mode == MODE_PREPARE && hcnt_q != 8'd0)
                || (mode == MODE_LOAD && word_index_i >= TgtBase && word_index_i < TgtEnd
                    && hcnt_q != 8'd0);
  assign in_ready_o = adv && !blocked;
  assign acc  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (acc && mode == MODE_LOAD) begin
      if (word_index_i < TgtBase) begin
        hdr_q[word_index_i] <= word_value_i;
      end else if (word_index_i < TgtEnd) begin
        tgt_q[3'(word_index_i - TgtBase)] <= word_value_i;
      end
    end
  end

  // First chain: prepare compresses header block 0 from HInit, hash uses the midstate.
  always_comb begin
    tag1_in.vld     = acc && (mode == MODE_PREPARE || mode == MODE_HASH);
    tag1_in.is_hash = (mode == MODE_HASH);
    if (mode == MODE_HASH) begin
      init1 = mid_q;
      msg1  = '0;
      msg1[0]  = bswap(hdr_q[16]);
      msg1[1]  = bswap(hdr_q[17]);
      msg1[2]  = bswap(hdr_q[18]);
      msg1[3]  = bswap(nonce_i);
      msg1[4]  = PadWord;
      msg1[15] = Len640Word;
    end else begin
      init1 = HInit;
      for (int i = 0; i < 16; i++) begin
        msg1[i] = bswap(hdr_q[i]);
      end
    end
  end

  shad_compress u_inner (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .tag_i(tag1_in), .init_i(init1), .msg_i(msg1),
    .tag_o(tag1_out), .digest_o(dig1)
  );

  assign prep_done = adv && tag1_out.vld && !tag1_out.is_hash;

  // The target top word is taken when the prepare request is accepted.
  always_ff @(posedge clk_i) begin
    if (prep_done) begin
      mid_q <= dig1;
    end
    if (acc && mode == MODE_PREPARE) begin
      ttop_q <= tgt_q[7];
    end
  end

  always_comb begin
    tag2_in     = tag1_out;
    tag2_in.vld = tag1_out.vld && tag1_out.is_hash;
    msg2        = '0;
    for (int i = 0; i < 8; i++) begin
      msg2[i] = dig1[i];
    end
    msg2[8]  = PadWord;
    msg2[15] = Len256Word;
  end

  shad_compress u_outer (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(adv),
    .tag_i(tag2_in), .init_i(HInit), .msg_i(msg2),
    .tag_o(tag2_out), .digest_o(dig2)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      limb_c[i] = bswap(dig2[i]);
    end
    share_c = 1'b1;
    decided = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!decided && limb_c[i] != tgt_q[i]) begin
        share_c = limb_c[i] < tgt_q[i];
        decided = 1'b1;
      end
    end
  end

  assign take_new = adv && tag2_out.vld;

  always_comb begin
    hcnt_d = hcnt_q;
    if (acc && mode == MODE_HASH) begin
      hcnt_d = hcnt_d + 8'd1;
    end
    if (take_new) begin
      hcnt_d = hcnt_d - 8'd1;
    end
    pcnt_d = pcnt_q;
    if (acc && mode == MODE_PREPARE) begin
      pcnt_d = pcnt_d + 7'd1;
    end
    if (prep_done) begin
      pcnt_d = pcnt_d - 7'd1;
    end
  end

  always_comb begin
    ov_d    = ov_q;
    hit_d   = hit_q;
    share_d = share_q;
    cnt_d   = cnt_q;
    if (ov_q && out_ready_i) begin
      if (hit_q && cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end else begin
        ov_d = 1'b0;
      end
    end
    if (take_new) begin
      ov_d    = 1'b1;
      hit_d   = !(limb_c[7] > ttop_q);
      share_d = share_c;
      cnt_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      cnt_q  <= 2'd0;
      hit_q  <= 1'b0;
      hcnt_q <= 8'd0;
      pcnt_q <= 7'd0;
    end else begin
      ov_q   <= ov_d;
      cnt_q  <= cnt_d;
      hit_q  <= hit_d;
      hcnt_q <= hcnt_d;
      pcnt_q <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    share_q <= share_d;
    if (take_new) begin
      for (int i = 0; i < 8; i++) begin
        limb_q[i] <= limb_c[i];
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign candidate_o   = hit_q;
  assign share_o       = hit_q && share_q;
  assign chunk_index_o = hit_q ? cnt_q : 2'd0;
  assign hash_chunk_o  = hit_q ? {limb_q[{cnt_q, 1'b1}], limb_q[{cnt_q, 1'b0}]} : 64'd0;
  assign last_o        = !hit_q || cnt_q == 2'd3;

`ifndef ASSERT_OFF
  a_miss_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !candidate_o |-> last_o && chunk_index_o == 2'd0)
    else $error("miss result is not a single final result");
  a_chunk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && candidate_o && !last_o |=>
    out_valid_o && chunk_index_o == $past(chunk_index_o) + 2'd1)
    else $error("hit chunks do not advance in order");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(limb_q[0]) && $stable(mid_q))
    else $error("pipeline state moved during a stall");
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !blocked |-> in_ready_o)
    else $error("input stalled with an empty output stage");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for sha256d_nonce_search: a short directed table, then random jobs.
// Depends on shad_pkg and the RTL under rtl/; the expected hashes come from a SHA-256d
// predictor kept in this file.
module testbench;
  import shad_pkg::*;

  typedef logic [7:0][31:0]  dig_t;
  typedef logic [15:0][31:0] blk_t;

  typedef struct packed {
    logic        candidate;
    logic        share;
    logic [1:0]  chunk;
    logic [63:0] value;
    logic        last;
  } exp_res_t;

  typedef enum logic [1:0] {
    WANT_NONE,
    WANT_HIT,
    WANT_PREDICTED
  } want_e;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  idx;
    logic [31:0] value;
    logic [31:0] nonce;
    want_e       want;
  } stim_row_t;

  localparam int unsigned SettleCycles = 150;
  localparam int unsigned StallLimit   = 5000;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitVec [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = 2'd0;
  logic [4:0]  word_index = 5'd0;
  logic [31:0] word_value = 32'd0;
  logic [31:0] nonce = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        candidate;
  logic        share;
  logic [1:0]  chunk_index;
  logic [63:0] hash_chunk;
  logic        last;

  sha256d_nonce_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .word_index_i  (word_index),
    .word_value_i  (word_value),
    .nonce_i       (nonce),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .candidate_o   (candidate),
    .share_o       (share),
    .chunk_index_o (chunk_index),
    .hash_chunk_o  (hash_chunk),
    .last_o        (last)
  );

  always #10 clk_i = ~clk_i;

  // Job state as the block should hold it.
  logic [31:0]  job_header [20];
  logic [31:0]  job_target [8];
  dig_t         job_midstate;
  logic [31:0]  job_target_top;
  exp_res_t     hash_results_q [$];

  int unsigned mismatches = 0;
  int unsigned n_requests = 0;
  int unsigned n_expected = 0;
  int unsigned n_hits = 0;
  int unsigned n_misses = 0;
  int unsigned n_shares = 0;
  int unsigned stall_cycles = 0;
  bit          steady = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] flip_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic dig_t sha_block(dig_t s, blk_t m);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    dig_t r;
    for (int i = 0; i < 16; i++) w[i] = m[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    r[0] = s[0] + a; r[1] = s[1] + b; r[2] = s[2] + c; r[3] = s[3] + d;
    r[4] = s[4] + e; r[5] = s[5] + f; r[6] = s[6] + g; r[7] = s[7] + h;
    return r;
  endfunction

  function automatic dig_t init_digest();
    dig_t s;
    for (int i = 0; i < 8; i++) s[i] = InitVec[i];
    return s;
  endfunction

  // Double hash of the header with this nonce; queues one miss or four hit chunks.
  function automatic void predict_nonce(logic [31:0] n);
    blk_t         m;
    dig_t         s;
    logic [31:0]  limb [8];
    logic         meets;
    exp_res_t     r;
    m = '0;
    m[0] = flip_bytes(job_header[16]);
    m[1] = flip_bytes(job_header[17]);
    m[2] = flip_bytes(job_header[18]);
    m[3] = flip_bytes(n);
    m[4] = 32'h80000000;
    m[15] = 32'h00000280;
    s = sha_block(job_midstate, m);
    m = '0;
    for (int i = 0; i < 8; i++) m[i] = s[i];
    m[8] = 32'h80000000;
    m[15] = 32'h00000100;
    s = sha_block(init_digest(), m);
    if (flip_bytes(s[7]) > job_target_top) begin
      hash_results_q.push_back('{1'b0, 1'b0, 2'd0, 64'd0, 1'b1});
      n_expected++;
      n_misses++;
      return;
    end
    for (int i = 0; i < 8; i++) limb[i] = flip_bytes(s[i]);
    meets = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (limb[i] != job_target[i]) begin
        meets = limb[i] < job_target[i];
        break;
      end
    end
    for (int k = 0; k < 4; k++) begin
      r = '{1'b1, meets, 2'(k), {limb[2*k+1], limb[2*k]}, k == 3};
      hash_results_q.push_back(r);
      n_expected++;
    end
    n_hits++;
    if (meets) n_shares++;
  endfunction

  function automatic void apply_request(mode_e m, logic [4:0] i, logic [31:0] v,
                                        logic [31:0] n);
    blk_t blk;
    case (m)
      MODE_LOAD: begin
        if (i < 5'd20) job_header[i] = v;
        else if (i < 5'd28) job_target[i - 5'd20] = v;
      end
      MODE_PREPARE: begin
        for (int k = 0; k < 16; k++) blk[k] = flip_bytes(job_header[k]);
        job_midstate = sha_block(init_digest(), blk);
        job_target_top = job_target[7];
      end
      MODE_HASH: predict_nonce(n);
      default: ;
    endcase
  endfunction

  // Stop sending until every result is back and the round chains have emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hash_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_request(mode_e m, logic [4:0] i, logic [31:0] v, logic [31:0] n);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode <= m;
    word_index <= i;
    word_value <= v;
    nonce <= n;
    do @(posedge clk_i); while (!in_ready);
    apply_request(m, i, v, n);
    n_requests++;
  endtask

  // Loads a whole job in shuffled order, with some ignored requests mixed in.
  task automatic load_job(logic [31:0] top, bit all_ones);
    int unsigned order [28];
    int unsigned j, t;
    logic [31:0] v;
    for (int k = 0; k < 28; k++) order[k] = k;
    for (int k = 27; k > 0; k--) begin
      j = $urandom_range(k);
      t = order[k]; order[k] = order[j]; order[j] = t;
    end
    for (int k = 0; k < 28; k++) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_request(MODE_NONE, 5'($urandom), $urandom, $urandom);
        else send_request(MODE_LOAD, 5'($urandom_range(28, 31)), $urandom, $urandom);
      end
      v = all_ones ? 32'hffffffff : $urandom;
      if (order[k] == 27) v = top;
      send_request(MODE_LOAD, 5'(order[k]), v, $urandom);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    exp_res_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (hash_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: chunk %0d value %h", chunk_index,
                                       hash_chunk);
      end else begin
        e = hash_results_q.pop_front();
        if (candidate !== e.candidate || share !== e.share || chunk_index !== e.chunk ||
            hash_chunk !== e.value || last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected cand %b share %b chunk %0d value %h last %b",
                     e.candidate, e.share, e.chunk, e.value, e.last);
            $display("          actual   cand %b share %b chunk %0d value %h last %b",
                     candidate, share, chunk_index, hash_chunk, last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results outstanding", hash_results_q.size());
      $display("[sha256d_nonce_search] ERROR");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{MODE_PREPARE, 5'd0,  32'h0,        32'h0,        WANT_NONE},
    '{MODE_HASH,    5'd0,  32'h0,        32'h00000000, WANT_HIT},
    '{MODE_HASH,    5'd31, 32'hffffffff, 32'hffffffff, WANT_HIT},
    '{MODE_HASH,    5'd0,  32'h0,        32'h80000000, WANT_HIT},
    '{MODE_HASH,    5'd0,  32'h0,        32'h00000001, WANT_HIT},
    '{MODE_NONE,    5'd31, 32'hffffffff, 32'hffffffff, WANT_NONE},
    '{MODE_LOAD,    5'd28, 32'h12345678, 32'h0,        WANT_NONE},
    '{MODE_LOAD,    5'd31, 32'hffffffff, 32'h0,        WANT_NONE},
    // Header word 19 is stored, but the nonce always takes its place.
    '{MODE_LOAD,    5'd19, 32'hdeadbeef, 32'h0,        WANT_NONE},
    '{MODE_HASH,    5'd0,  32'h0,        32'h00000000, WANT_HIT},
    '{MODE_HASH,    5'd0,  32'h0,        32'h7fffffff, WANT_HIT},
    '{MODE_LOAD,    5'd16, 32'hffffffff, 32'h0,        WANT_NONE},
    '{MODE_LOAD,    5'd18, 32'h80000001, 32'h0,        WANT_NONE},
    '{MODE_LOAD,    5'd0,  32'hffffffff, 32'h0,        WANT_NONE},
    '{MODE_LOAD,    5'd15, 32'h00000001, 32'h0,        WANT_NONE},
    '{MODE_PREPARE, 5'd0,  32'h0,        32'h0,        WANT_NONE},
    '{MODE_HASH,    5'd0,  32'h0,        32'ha5a5a5a5, WANT_HIT},
    // A zero top target word turns nearly every nonce into a miss.
    '{MODE_LOAD,    5'd27, 32'h00000000, 32'h0,        WANT_NONE},
    '{MODE_PREPARE, 5'd0,  32'h0,        32'h0,        WANT_NONE},
    '{MODE_HASH,    5'd0,  32'h0,        32'h00000000, WANT_PREDICTED},
    '{MODE_HASH,    5'd0,  32'h0,        32'hffffffff, WANT_PREDICTED},
    '{MODE_HASH,    5'd0,  32'h0,        32'h5a5a5a5a, WANT_PREDICTED}
  };

  initial begin
    int unsigned before_n;
    logic [31:0] top;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an all-zero header against an all-ones target always meets it.
    for (int k = 0; k < 20; k++) send_request(MODE_LOAD, 5'(k), 32'h0, 32'h0);
    for (int k = 20; k < 28; k++) send_request(MODE_LOAD, 5'(k), 32'hffffffff, 32'h0);
    foreach (directed[r]) begin
      before_n = n_expected;
      send_request(directed[r].mode, directed[r].idx, directed[r].value, directed[r].nonce);
      if (directed[r].want == WANT_NONE && n_expected != before_n) begin
        mismatches++;
        $display("row %0d: request should give no result", r);
      end
      if (directed[r].want == WANT_HIT && (n_expected != before_n + 4 ||
          !hash_results_q[$-3].candidate || !hash_results_q[$-3].share)) begin
        mismatches++;
        $display("row %0d: nonce %h should meet the all-ones target", r, directed[r].nonce);
      end
    end
    wait_idle();

    // Random jobs with random nonces; the top target word sets the hit rate.
    for (int job = 0; job < 9; job++) begin
      steady = (job == 4);
      case (job % 4)
        0: top = 32'hffffffff;
        1: top = 32'h00000000;
        2: top = 32'h80000000;
        default: top = $urandom;
      endcase
      load_job(top, job == 8);
      send_request(MODE_PREPARE, 5'($urandom), $urandom, $urandom);
      for (int k = 0; k < 25; k++) begin
        case ($urandom_range(19))
          0: send_request(MODE_NONE, 5'($urandom), $urandom, $urandom);
          1: send_request(MODE_LOAD, 5'($urandom_range(0, 15)), $urandom, $urandom);
          2: send_request(MODE_HASH, 5'($urandom), $urandom,
                          $urandom_range(1) ? 32'hffffffff : 32'h0);
          default: send_request(MODE_HASH, 5'($urandom), $urandom, $urandom);
        endcase
      end
      // Now and then a fresh prepare on the current header, without reloading.
      if ($urandom_range(2) == 0) begin
        send_request(MODE_PREPARE, 5'd0, 32'h0, 32'h0);
        for (int k = 0; k < 5; k++) send_request(MODE_HASH, 5'd0, 32'h0, $urandom);
      end
    end
    steady = 1'b0;
    wait_idle();

    if (hash_results_q.size() != 0) mismatches++;
    $display("covered %0d requests: %0d hits (%0d meeting the full target), %0d misses",
             n_requests, n_hits, n_shares, n_misses);
    $display("with ignored modes and indexes, mid-job reloads and random stalls on both sides");
    if (mismatches == 0) begin
      $display("[sha256d_nonce_search] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[sha256d_nonce_search] ERROR");
    end
    $finish;
  end

endmodule
